>>> design/stl_pkg.sv
// Shared types and constants for the shell token lexer.
// No dependencies; imported by every lexer module.
package stl_pkg;

  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [7:0] CH_PIPE  = 8'h7C;  // '|'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SQUOT = 8'h27;  // single quote
  localparam logic [7:0] CH_DQUOT = 8'h22;  // double quote
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [2:0] K_WORD   = 3'd0;
  localparam logic [2:0] K_PIPE   = 3'd1;
  localparam logic [2:0] K_RIN    = 3'd2;
  localparam logic [2:0] K_ROUT   = 3'd3;
  localparam logic [2:0] K_APPEND = 3'd4;
  localparam logic [2:0] K_AND    = 3'd5;
  localparam logic [2:0] K_BG     = 3'd6;
  localparam logic [2:0] K_EOF    = 3'd7;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] word_byte;
    logic       byte_valid;
    logic       word_first;
    logic       word_last;
    logic       run_last;
  } res_t;

  // Results of one byte, handed from the lexer core to the result queue.
  typedef struct packed {
    logic       en;
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] byte_v,
                                  logic valid, logic first, logic last);
    res_t r;
    r.token_kind = kind;
    r.word_byte  = byte_v;
    r.byte_valid = valid;
    r.word_first = first;
    r.word_last  = last;
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

>>> design/stl_core.sv
// Lexer core: input register, lexer state and the per-byte step logic.
// Depends on stl_pkg; feeds stl_outq.
module stl_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char_in,
  input  logic          space_ok,
  output stl_pkg::push_t push
);
  import stl_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE = 2'd0,
    M_WORD = 2'd1,
    M_OP   = 2'd2
  } mode_t;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       adv;

  mode_t      mode_r, mode_nxt;
  logic       qopen_r, qopen_nxt;
  logic [7:0] qchar_r, qchar_nxt;
  logic       strip_r, strip_nxt;
  logic [7:0] held_r, held_nxt;
  logic [1:0] wlc_r, wlc_nxt;
  logic       started_r, started_nxt;
  logic [7:0] prior_r, prior_nxt;

  logic [7:0] c;
  logic       c_blank, c_quote, c_op;
  logic       do_idle;
  logic [1:0] cnt;
  res_t       res [2];

  assign adv      = s1_valid_r && space_ok;
  assign in_stall = s1_valid_r && !adv;

  assign c       = s1_byte_r;
  assign c_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign c_quote = (c == CH_SQUOT) || (c == CH_DQUOT);
  assign c_op    = (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT) || (c == CH_AMP);

  always_comb begin
    mode_nxt    = mode_r;
    qopen_nxt   = qopen_r;
    qchar_nxt   = qchar_r;
    strip_nxt   = strip_r;
    held_nxt    = held_r;
    wlc_nxt     = wlc_r;
    started_nxt = started_r;
    prior_nxt   = prior_r;
    cnt         = 2'd0;
    res[0]      = '0;
    res[1]      = '0;
    do_idle     = 1'b0;

    unique case (mode_r)
      M_WORD: begin
        if (c == CH_NUL || (!qopen_r && (c_blank || c_op))) begin
          // word ends: flush the delayed byte with the last mark
          if (!strip_r) begin
            res[cnt[0]] = mk_res(K_WORD, held_r, 1'b1, !started_r, 1'b1);
          end else if (wlc_r == 2'd1) begin
            res[cnt[0]] = mk_res(K_WORD, held_r, 1'b1, 1'b1, 1'b1);
          end else if (wlc_r == 2'd2) begin
            res[cnt[0]] = mk_res(K_WORD, CH_NUL, 1'b0, 1'b1, 1'b1);
          end else begin
            res[cnt[0]] = mk_res(K_WORD, prior_r, 1'b1, !started_r, 1'b1);
          end
          cnt         = cnt + 2'd1;
          mode_nxt    = M_IDLE;
          qopen_nxt   = 1'b0;
          qchar_nxt   = '0;
          strip_nxt   = 1'b0;
          held_nxt    = '0;
          prior_nxt   = '0;
          wlc_nxt     = 2'd0;
          started_nxt = 1'b0;
          do_idle     = 1'b1;
        end else begin
          if (!qopen_r) begin
            if (c_quote) begin
              qopen_nxt = 1'b1;
              qchar_nxt = c;
            end
          end else if (c == qchar_r) begin
            qopen_nxt = 1'b0;
          end
          if (!strip_r) begin
            res[cnt[0]] = mk_res(K_WORD, held_r, 1'b1, !started_r, 1'b0);
            cnt         = cnt + 2'd1;
            started_nxt = 1'b1;
            held_nxt    = c;
          end else if (wlc_r == 2'd1) begin
            held_nxt = c;
          end else if (wlc_r == 2'd2) begin
            prior_nxt = held_r;
            held_nxt  = c;
          end else begin
            res[cnt[0]] = mk_res(K_WORD, prior_r, 1'b1, !started_r, 1'b0);
            cnt         = cnt + 2'd1;
            started_nxt = 1'b1;
            prior_nxt   = held_r;
            held_nxt    = c;
          end
          if (wlc_r != 2'd3) wlc_nxt = wlc_r + 2'd1;
        end
      end
      M_OP: begin
        mode_nxt = M_IDLE;
        held_nxt = '0;
        if (c == held_r) begin
          res[cnt[0]] = mk_res((held_r == CH_GT) ? K_APPEND : K_AND,
                               CH_NUL, 1'b0, 1'b0, 1'b0);
        end else begin
          res[cnt[0]] = mk_res((held_r == CH_GT) ? K_ROUT : K_BG,
                               CH_NUL, 1'b0, 1'b0, 1'b0);
          do_idle = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
      default: begin
        mode_nxt = M_IDLE;
        do_idle  = 1'b1;
      end
    endcase

    if (do_idle) begin
      if (c == CH_NUL) begin
        res[cnt[0]] = mk_res(K_EOF, CH_NUL, 1'b0, 1'b0, 1'b0);
        cnt         = cnt + 2'd1;
        mode_nxt    = M_IDLE;
        qopen_nxt   = 1'b0;
        qchar_nxt   = '0;
        strip_nxt   = 1'b0;
        held_nxt    = '0;
        wlc_nxt     = 2'd0;
        started_nxt = 1'b0;
        prior_nxt   = '0;
      end else if (c_blank) begin
        mode_nxt = M_IDLE;
      end else if (c == CH_PIPE) begin
        res[cnt[0]] = mk_res(K_PIPE, CH_NUL, 1'b0, 1'b0, 1'b0);
        cnt         = cnt + 2'd1;
        mode_nxt    = M_IDLE;
      end else if (c == CH_LT) begin
        res[cnt[0]] = mk_res(K_RIN, CH_NUL, 1'b0, 1'b0, 1'b0);
        cnt         = cnt + 2'd1;
        mode_nxt    = M_IDLE;
      end else if (c == CH_GT || c == CH_AMP) begin
        mode_nxt = M_OP;
        held_nxt = c;
      end else begin
        mode_nxt    = M_WORD;
        strip_nxt   = c_quote;
        qopen_nxt   = c_quote;
        qchar_nxt   = c_quote ? c : CH_NUL;
        held_nxt    = c;
        prior_nxt   = '0;
        wlc_nxt     = 2'd1;
        started_nxt = 1'b0;
      end
    end

    if (cnt == 2'd1) res[0].run_last = 1'b1;
    if (cnt == 2'd2) res[1].run_last = 1'b1;
  end

  assign push.en  = adv;
  assign push.cnt = cnt;
  assign push.r0  = res[0];
  assign push.r1  = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) s1_byte_r <= in_char_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      qopen_r   <= 1'b0;
      qchar_r   <= '0;
      strip_r   <= 1'b0;
      held_r    <= '0;
      wlc_r     <= 2'd0;
      started_r <= 1'b0;
      prior_r   <= '0;
    end else if (adv) begin
      mode_r    <= mode_nxt;
      qopen_r   <= qopen_nxt;
      qchar_r   <= qchar_nxt;
      strip_r   <= strip_nxt;
      held_r    <= held_nxt;
      wlc_r     <= wlc_nxt;
      started_r <= started_nxt;
      prior_r   <= prior_nxt;
    end
  end

  a_op_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_OP) |-> (held_r == CH_GT || held_r == CH_AMP))
    else $error("pending operator byte is not > or &");

  a_quote_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    qopen_r |-> (mode_r == M_WORD))
    else $error("quote open outside a word");

  a_strip_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_WORD) |-> (wlc_r != 2'd0))
    else $error("word active with zero length class");

endmodule

>>> design/stl_outq.sv
// Result queue: small flip-flop FIFO taking up to two results per cycle.
// Depends on stl_pkg; fed by stl_core.
module stl_outq #(
  parameter int unsigned DEPTH = stl_pkg::OUTQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stl_pkg::push_t push,
  output logic          space_ok,
  output logic          out_valid,
  input  logic          out_stall,
  output stl_pkg::res_t  head
);
  import stl_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r, wr1;
  logic [CW-1:0] count_r;
  logic          pop;
  logic [CW-1:0] n_push;

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign wr1       = inc(wr_r);
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign space_ok  = (count_r <= CW'(DEPTH - 2));
  assign head      = mem_r[rd_r];
  assign n_push    = push.en ? CW'(push.cnt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push.en && push.cnt == 2'd1) wr_r <= wr1;
      if (push.en && push.cnt == 2'd2) wr_r <= inc(wr1);
      if (pop) rd_r <= inc(rd_r);
      count_r <= count_r + n_push - (pop ? CW'(1) : '0);
    end
    if (push.en && push.cnt != 2'd0) mem_r[wr_r] <= push.r0;
    if (push.en && push.cnt == 2'd2) mem_r[wr1] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.en && push.cnt != 2'd0) |-> (count_r <= CW'(DEPTH - 2)))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue count out of range");

endmodule

>>> design/shell_token_lexer.sv
// Shell command-line token lexer, top level.
// Depends on stl_pkg, stl_core and stl_outq.
//
// One command-line byte is taken per transfer on the in_ channel and turned
// into zero, one or two token results on the out_ channel. A zero byte closes
// any open word, gives an EOF result and returns the lexer to its reset
// state. Blanks separate tokens; '|' and '<' give pipe and input redirect;
// '>' and '&' wait one byte to pair into append or and, else give output
// redirect or background. Word bytes come out one per result, one byte behind
// the input (two for quote-stripped words) so that word_last is exact;
// run_last marks the last result caused by a given input byte. Rate: one byte
// per cycle while the consumer keeps up; a byte is registered, stepped through
// the lexer logic when the queue has room and its results land in a small
// result queue (OUTQ_DEPTH entries). The byte step waits while the queue holds
// more than OUTQ_DEPTH-2 results, so bytes that cause two results, or a
// stalled consumer, slow input to the rate results are drained (one per
// cycle). Results are registered in the queue and read from its head.
module shell_token_lexer #(
  parameter int unsigned OUTQ_DEPTH = stl_pkg::OUTQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_word_byte,
  output logic       out_byte_valid,
  output logic       out_word_first,
  output logic       out_word_last,
  output logic       out_run_last
);
  import stl_pkg::*;

  push_t push;      // results of the byte stepped this cycle
  logic  space_ok;  // queue can take two more results
  res_t  head;      // oldest queued result

  stl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .space_ok   (space_ok),
    .push       (push)
  );

  stl_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Result fields straight off the queue head.
  assign out_token_kind = head.token_kind;
  assign out_word_byte  = head.word_byte;
  assign out_byte_valid = head.byte_valid;
  assign out_word_first = head.word_first;
  assign out_word_last  = head.word_last;
  assign out_run_last   = head.run_last;

endmodule
